// ===== design/rscs_pkg.sv =====
// Package for the rotation-synced column sequencer.
// Holds request codes, store read source codes and fixed port widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rscs_pkg;

	// fixed payload widths of the channels
	localparam int unsigned SECT_BITS = 8;
	localparam int unsigned LED_PORT_BITS = 16;
	localparam int unsigned INDEX_BITS = 8;

	// request kinds
	typedef enum logic [0:0] {
		OP_TICK  = 1'b0,
		OP_WRITE = 1'b1
	} op_e_t;

	// where a registered store read takes its data from
	typedef enum logic [1:0] {
		SRC_ZERO   = 2'd0,
		SRC_MEM    = 2'd1,
		SRC_BYPASS = 2'd2
	} rd_src_t;

endpackage : rscs_pkg

`default_nettype wire

// ===== design/rscs_if.sv =====
// Channel interfaces for the rotation-synced column sequencer.
// rscs_item_if carries tick and write requests, rscs_result_if carries results.
// Depends on rscs_pkg for the fixed field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rscs_item_if;
	import rscs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  operation;
	logic                  sensor_level;
	logic [INDEX_BITS-1:0] column_index;
	logic [15:0]           column_data;

	modport source (output valid, operation, sensor_level, column_index, column_data,
		input ready);
	modport sink (input valid, operation, sensor_level, column_index, column_data,
		output ready);
endinterface : rscs_item_if

interface rscs_result_if;
	import rscs_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [LED_PORT_BITS-1:0] led_drive;
	logic [SECT_BITS-1:0]     current_sector;
	logic                     revolution_start;

	modport source (output valid, led_drive, current_sector, revolution_start,
		input ready);
	modport sink (input valid, led_drive, current_sector, revolution_start,
		output ready);
endinterface : rscs_result_if

`default_nettype wire

// ===== design/rscs_store.sv =====
// Column pattern store: one write port, two registered read ports.
// Read ports deliver the columns of the next sector and the one after it,
// plus a shadow copy of sector 0. Depends on rscs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rscs_store #(
	parameter int unsigned SECTORS = 180,
	parameter int unsigned LED_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [$clog2(SECTORS)-1:0]     wr_addr,
	input  wire logic [LED_BITS-1:0]            wr_data,
	input  wire logic [rscs_pkg::SECT_BITS-1:0] rd_sector,
	output logic      [LED_BITS-1:0]            col_cur,
	output logic      [LED_BITS-1:0]            col_nxt,
	output logic      [LED_BITS-1:0]            col_zero
);
	import rscs_pkg::*;

	localparam int unsigned AW = $clog2(SECTORS);
	localparam int unsigned RW = SECT_BITS + 1;

	logic [LED_BITS-1:0] mem [SECTORS];
	logic [SECTORS-1:0]  valid_q;

	logic [RW-1:0]       addr_a, addr_b;
	logic                rng_a, rng_b;
	logic [AW-1:0]       ra_a, ra_b;
	rd_src_t             src_a, src_b;
	rd_src_t             src_a_q, src_b_q;
	logic [LED_BITS-1:0] mem_a_q, mem_b_q;
	logic [LED_BITS-1:0] byp_a_q, byp_b_q;
	logic [LED_BITS-1:0] zero_q;

	// read addresses: the coming sector and its successor, clamped when past the end
	always_comb begin
		addr_a = {1'b0, rd_sector};
		addr_b = {1'b0, rd_sector} + RW'(1);
		rng_a  = addr_a < RW'(SECTORS);
		rng_b  = addr_b < RW'(SECTORS);
		ra_a   = rng_a ? addr_a[AW-1:0] : '0;
		ra_b   = rng_b ? addr_b[AW-1:0] : '0;
	end

	// source select: never written entries read as zero, same-cycle writes bypass
	always_comb begin
		if (!rng_a) begin
			src_a = SRC_ZERO;
		end else if (wr_en && wr_addr == ra_a) begin
			src_a = SRC_BYPASS;
		end else if (valid_q[ra_a]) begin
			src_a = SRC_MEM;
		end else begin
			src_a = SRC_ZERO;
		end
		if (!rng_b) begin
			src_b = SRC_ZERO;
		end else if (wr_en && wr_addr == ra_b) begin
			src_b = SRC_BYPASS;
		end else if (valid_q[ra_b]) begin
			src_b = SRC_MEM;
		end else begin
			src_b = SRC_ZERO;
		end
	end

	// storage array and registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		mem_a_q <= mem[ra_a];
		mem_b_q <= mem[ra_b];
		byp_a_q <= wr_data;
		byp_b_q <= wr_data;
	end

	// valid bits, read sources and the sector 0 shadow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			src_a_q <= SRC_ZERO;
			src_b_q <= SRC_ZERO;
			zero_q  <= '0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (wr_en && wr_addr == AW'(0)) begin
				zero_q <= wr_data;
			end
			src_a_q <= src_a;
			src_b_q <= src_b;
		end
	end

	// read data muxes
	always_comb begin
		unique case (src_a_q)
			SRC_MEM:    col_cur = mem_a_q;
			SRC_BYPASS: col_cur = byp_a_q;
			default:    col_cur = '0;
		endcase
		unique case (src_b_q)
			SRC_MEM:    col_nxt = mem_b_q;
			SRC_BYPASS: col_nxt = byp_b_q;
			default:    col_nxt = '0;
		endcase
	end

	assign col_zero = zero_q;

	a_bypass_needs_write: assert property (@(posedge clk) disable iff (!arst_n)
		(src_a == SRC_BYPASS || src_b == SRC_BYPASS) |-> wr_en)
		else $error("store bypass selected without a write");

	a_zero_shadow: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && wr_addr == AW'(0)) |=> zero_q == $past(wr_data))
		else $error("sector 0 shadow missed a write");

	a_past_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!rng_a |=> col_cur == '0)
		else $error("read past the last sector returned data");

endmodule : rscs_store

`default_nettype wire

// ===== design/rscs_sweep.sv =====
// Rotation timing core: tick counter, period capture, sector window tracking
// and held LED drive. Window bounds are kept as running accumulators.
// Depends on rscs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rscs_sweep #(
	parameter int unsigned SECTORS = 180,
	parameter int unsigned COUNT_BITS = 24,
	parameter int unsigned LED_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            fire,
	input  wire rscs_pkg::op_e_t                 op,
	input  wire logic                            level,
	input  wire logic [rscs_pkg::INDEX_BITS-1:0] wr_index,
	input  wire logic [LED_BITS-1:0]             wr_pattern,
	input  wire logic [LED_BITS-1:0]             col_cur,
	input  wire logic [LED_BITS-1:0]             col_nxt,
	input  wire logic [LED_BITS-1:0]             col_zero,
	output logic                                 wr_en,
	output logic      [$clog2(SECTORS)-1:0]      wr_addr,
	output logic      [LED_BITS-1:0]             wr_data,
	output logic      [rscs_pkg::SECT_BITS-1:0]  sector_d,
	output logic      [LED_BITS-1:0]             drive_d,
	output logic                                 start_d
);
	import rscs_pkg::*;

	localparam int unsigned AW = $clog2(SECTORS);
	// scaled count and window bounds: count * SECTORS and period * (sector + 1)
	localparam int unsigned W = COUNT_BITS + SECT_BITS + 1;

	logic [COUNT_BITS-1:0] cnt_q, period_q;
	logic [W-1:0]          scaled_q, lo_q, hi_q;
	logic [SECT_BITS-1:0]  sector_q;
	logic                  armed_q;
	logic [LED_BITS-1:0]   drive_q;

	logic                  is_tick, capture, adv, load;
	logic [COUNT_BITS-1:0] cnt1, cnt2, per2;
	logic [W-1:0]          sc1, sc2, lo2, hi2, lo3, hi3;
	logic [SECT_BITS-1:0]  sec2, sec3;
	logic [LED_BITS-1:0]   col_sel;

	// store write request
	always_comb begin
		wr_en   = fire && op == OP_WRITE && wr_index < INDEX_BITS'(SECTORS);
		wr_addr = wr_index[AW-1:0];
		wr_data = wr_pattern;
	end

	// one tick: count, capture or re-arm, sector advance, drive
	always_comb begin
		is_tick = fire && op == OP_TICK;

		// saturating count and its scaled copy
		cnt1 = (&cnt_q) ? cnt_q : cnt_q + COUNT_BITS'(1);
		sc1  = (&cnt_q) ? scaled_q : scaled_q + W'(SECTORS);

		// index capture restarts count, sector and window
		capture = is_tick && !level && !armed_q;
		per2 = capture ? cnt1 : period_q;
		cnt2 = capture ? '0 : cnt1;
		sc2  = capture ? '0 : sc1;
		sec2 = capture ? '0 : sector_q;
		lo2  = capture ? '0 : lo_q;
		hi2  = capture ? W'(cnt1) : hi_q;

		// at most one sector step per tick, capped past the end
		adv = is_tick && sc2 > hi2 && {1'b0, sec2} <= (SECT_BITS + 1)'(SECTORS)
			&& sec2 != '1;
		sec3 = adv ? sec2 + SECT_BITS'(1) : sec2;
		lo3  = adv ? hi2 : lo2;
		hi3  = adv ? hi2 + W'(per2) : hi2;

		// column of the sector now current
		if (adv) begin
			col_sel = col_nxt;
		end else if (capture) begin
			col_sel = col_zero;
		end else begin
			col_sel = col_cur;
		end

		// drive loads only while the count is inside the sector window
		load = is_tick && {1'b0, sec3} < (SECT_BITS + 1)'(SECTORS)
			&& sc2 >= lo3 && sc2 < hi3;
		drive_d  = load ? col_sel : drive_q;
		sector_d = is_tick ? sec3 : sector_q;
		start_d  = capture;
	end

	// timing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			period_q <= '0;
			scaled_q <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			sector_q <= '0;
			armed_q  <= 1'b0;
			drive_q  <= '0;
		end else begin
			if (is_tick) begin
				cnt_q    <= cnt2;
				period_q <= per2;
				scaled_q <= sc2;
				lo_q     <= lo3;
				hi_q     <= hi3;
				sector_q <= sec3;
				if (capture) begin
					armed_q <= 1'b1;
				end else if (level) begin
					armed_q <= 1'b0;
				end
			end
			if (load) begin
				drive_q <= col_sel;
			end
		end
	end

	a_window_width: assert property (@(posedge clk) disable iff (!arst_n)
		hi_q == lo_q + W'(period_q))
		else $error("sector window width differs from the period");

	a_capture_restart: assert property (@(posedge clk) disable iff (!arst_n)
		capture |=> sector_q == '0 && cnt_q == '0 && scaled_q == '0 && armed_q)
		else $error("capture did not restart count and sector");

	a_sector_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(is_tick && !capture) |=> sector_q >= $past(sector_q))
		else $error("sector moved backward without a capture");

	a_sector_cap: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, sector_q} <= (SECT_BITS + 1)'(SECTORS + 1))
		else $error("sector ran past its ceiling");

endmodule : rscs_sweep

`default_nettype wire

// ===== design/rotation_synced_column_sequencer.sv =====
// Top level of the rotation-synced column sequencer.
// Input request register, timing core, column store and result register.
// Depends on rscs_pkg, rscs_if, rscs_store and rscs_sweep.
//
//  Channel  Dir  Payload
//  item     in   operation, sensor_level, column_index, column_data
//  result   out  led_drive, current_sector, revolution_start
//
// Requests wait in the input register; a full register feeds one request per
// cycle into the result register while that is free, one result per request.
// Window bounds are running sums, so no multiplier sits in the per-tick path.
// Reset clears valid flags and timing state; columns read as zero until written.
// A stalled result holds the input register; a new request is taken in the same
// cycle that the held one moves on.
`timescale 1ns / 1ps
`default_nettype none

module rotation_synced_column_sequencer #(
	parameter int unsigned SECTORS = 180,
	parameter int unsigned COUNT_BITS = 24,
	parameter int unsigned LED_BITS = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	rscs_item_if.sink item,
	rscs_result_if.source result
);
	import rscs_pkg::*;

	localparam int unsigned AW = $clog2(SECTORS);

	logic                  valid_s1;
	op_e_t                 op_s1;
	logic                  level_s1;
	logic [INDEX_BITS-1:0] index_s1;
	logic [LED_BITS-1:0]   data_s1;
	logic                  fire;

	logic [LED_BITS+LED_PORT_BITS-1:0] data_ext;
	logic [LED_BITS+LED_PORT_BITS-1:0] drive_ext;

	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [LED_BITS-1:0]   wr_data;
	logic [SECT_BITS-1:0]  sector_d;
	logic [LED_BITS-1:0]   drive_d;
	logic                  start_d;
	logic [LED_BITS-1:0]   col_cur, col_nxt, col_zero;

	logic                     out_valid_q;
	logic [LED_PORT_BITS-1:0] led_q;
	logic [SECT_BITS-1:0]     sector_q;
	logic                     start_q;

	// handshake: the held request moves on whenever the result slot frees up
	assign fire        = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready  = !valid_s1 || fire;
	assign data_ext    = {{LED_BITS{1'b0}}, item.column_data};
	assign drive_ext   = {{LED_PORT_BITS{1'b0}}, drive_d};

	// input request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1    <= op_e_t'(item.operation);
			level_s1 <= item.sensor_level;
			index_s1 <= item.column_index;
			data_s1  <= data_ext[LED_BITS-1:0];
		end
	end

	rscs_sweep #(
		.SECTORS    (SECTORS),
		.COUNT_BITS (COUNT_BITS),
		.LED_BITS   (LED_BITS)
	) u_sweep (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.op         (op_s1),
		.level      (level_s1),
		.wr_index   (index_s1),
		.wr_pattern (data_s1),
		.col_cur    (col_cur),
		.col_nxt    (col_nxt),
		.col_zero   (col_zero),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.sector_d   (sector_d),
		.drive_d    (drive_d),
		.start_d    (start_d)
	);

	rscs_store #(
		.SECTORS  (SECTORS),
		.LED_BITS (LED_BITS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_sector (sector_d),
		.col_cur   (col_cur),
		.col_nxt   (col_nxt),
		.col_zero  (col_zero)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			led_q    <= drive_ext[LED_PORT_BITS-1:0];
			sector_q <= sector_d;
			start_q  <= start_d;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.led_drive        = led_q;
	assign result.current_sector   = sector_q;
	assign result.revolution_start = start_q;

endmodule : rotation_synced_column_sequencer

`default_nettype wire

// ===== tb/sv/rotation_synced_column_sequencer_tb.sv =====
// Testbench for rotation_synced_column_sequencer: drives tick and column write requests,
// predicts every result in a scoreboard class and checks it field by field.
// Depends on rscs_pkg, rscs_if and the design sources.
`timescale 1ns / 1ps

module rotation_synced_column_sequencer_tb;
	import rscs_pkg::*;

	localparam int unsigned NUM_SECTORS = 180;
	localparam logic [23:0] COUNT_LIMIT = 24'hFFFFFF;
	localparam int TOTAL_REQUESTS = 1650;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 20;
	localparam int LONG_HOLD = 90;

	typedef struct packed {
		logic [15:0] led_drive;
		logic [7:0]  current_sector;
		logic        revolution_start;
	} column_result_t;

	// Predicts the display sequencer and checks results in order
	class column_scoreboard;
		bit [23:0]      ticks;
		bit [23:0]      period;
		bit [7:0]       sector;
		bit             armed;
		bit [15:0]      drive;
		bit [15:0]      columns [NUM_SECTORS];
		column_result_t awaited [$];
		int             errors;
		int             tick_reqs;
		int             write_reqs;
		int             dropped_writes;
		int             revolutions;
		int             top_sector;

		function new();
			ticks = '0;
			period = '0;
			sector = '0;
			armed = 1'b0;
			drive = '0;
			foreach (columns[i]) columns[i] = '0;
			errors = 0;
			tick_reqs = 0;
			write_reqs = 0;
			dropped_writes = 0;
			revolutions = 0;
			top_sector = 0;
		endfunction

		function void note_request(op_e_t op, logic lvl, logic [7:0] idx, logic [15:0] dat);
			column_result_t r;
			longint unsigned scaled;
			longint unsigned lo;
			longint unsigned hi;
			r.revolution_start = 1'b0;
			if (op == OP_WRITE) begin
				write_reqs++;
				if (idx < NUM_SECTORS)
					columns[idx] = dat;
				else
					dropped_writes++;
			end else begin
				tick_reqs++;
				if (ticks != COUNT_LIMIT)
					ticks = ticks + 1'b1;
				// index pulse: capture once, re-armed by a high level
				if (!lvl) begin
					if (!armed) begin
						period = ticks;
						armed = 1'b1;
						ticks = '0;
						sector = '0;
						r.revolution_start = 1'b1;
						revolutions++;
					end
				end else begin
					armed = 1'b0;
				end
				// one sector step at most per tick
				scaled = longint'(ticks) * NUM_SECTORS;
				hi = longint'(period) * (longint'(sector) + 1);
				if (scaled > hi && sector <= NUM_SECTORS && sector < 8'd255)
					sector = sector + 1'b1;
				// drive follows the store only inside the sector window
				lo = longint'(period) * longint'(sector);
				hi = longint'(period) * (longint'(sector) + 1);
				if (sector < NUM_SECTORS && scaled >= lo && scaled < hi)
					drive = columns[sector];
				if (sector > top_sector)
					top_sector = sector;
			end
			r.led_drive = drive;
			r.current_sector = sector;
			awaited.push_back(r);
		endfunction

		function void check_result(column_result_t got);
			column_result_t want;
			if (awaited.size() == 0) begin
				$error("result with nothing expected: drive %h sector %0d start %0b",
					got.led_drive, got.current_sector, got.revolution_start);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.led_drive !== want.led_drive) begin
				$error("led_drive: expected %h, got %h", want.led_drive, got.led_drive);
				errors++;
			end
			if (got.current_sector !== want.current_sector) begin
				$error("current_sector: expected %0d, got %0d",
					want.current_sector, got.current_sector);
				errors++;
			end
			if (got.revolution_start !== want.revolution_start) begin
				$error("revolution_start: expected %0b, got %0b",
					want.revolution_start, got.revolution_start);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	rscs_item_if item_ch ();
	rscs_result_if result_ch ();

	column_scoreboard sb;
	int sent;
	int results_taken;
	int cycles;
	bit steady;
	bit held_once;
	bit drained_once;

	rotation_synced_column_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	always #2 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// one request on the item channel, with random idle cycles before it
	task automatic push_request(input op_e_t op, input logic lvl, input logic [7:0] idx,
		input logic [15:0] dat);
		logic taken;
		while (!steady && $urandom_range(0, 99) < 19) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.operation <= op;
		item_ch.sensor_level <= lvl;
		item_ch.column_index <= idx;
		item_ch.column_data <= dat;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = item_ch.ready;
			@(posedge clk);
		end
		sb.note_request(op, lvl, idx, dat);
		sent++;
	endtask

	task automatic tick(input logic lvl);
		push_request(OP_TICK, lvl, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
	endtask

	task automatic write_column(input logic [7:0] idx, input logic [15:0] dat);
		push_request(OP_WRITE, 1'($urandom_range(0, 1)), idx, dat);
	endtask

	task automatic random_write();
		logic [7:0] idx;
		if ($urandom_range(0, 9) == 0)
			idx = 8'($urandom_range(NUM_SECTORS, 255));
		else
			idx = 8'($urandom_range(0, NUM_SECTORS - 1));
		write_column(idx, 16'($urandom_range(0, 65535)));
	endtask

	// one revolution: sensor high for a while, then a short index pulse
	task automatic spin_revolution();
		int high_ticks;
		int low_ticks;
		int sel;
		int i;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			high_ticks = $urandom_range(1, 8);
		else if (sel < 85)
			high_ticks = $urandom_range(20, 200);
		else
			high_ticks = $urandom_range(250, 500);
		low_ticks = $urandom_range(1, 3);
		for (i = 0; i < high_ticks + low_ticks && sent < TOTAL_REQUESTS; i++) begin
			if ($urandom_range(0, 99) < 15)
				random_write();
			tick(i < high_ticks);
			steady = (sent >= 1000 && sent < 1250);
		end
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// noise: random requests of any kind
	task automatic noise_burst();
		int n;
		int i;
		n = $urandom_range(1, 10);
		for (i = 0; i < n && sent < TOTAL_REQUESTS; i++) begin
			if ($urandom_range(0, 1))
				write_column(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
			else
				tick(1'($urandom_range(0, 1)));
		end
	endtask

	// result side: random stalls plus one long hold-off
	initial begin
		int hold_left;
		bit took;
		column_result_t got;
		hold_left = 0;
		took = 1'b0;
		got = '0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (took) begin
				sb.check_result(got);
				results_taken++;
				if (results_taken == 300 && !held_once) begin
					held_once = 1'b1;
					hold_left = LONG_HOLD;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (!steady && $urandom_range(0, 99) < 19) begin
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
			@(negedge clk);
			took = result_ch.valid && result_ch.ready;
			got.led_drive = result_ch.led_drive;
			got.current_sector = result_ch.current_sector;
			got.revolution_start = result_ch.revolution_start;
		end
	end

	// main sequence
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.operation = OP_TICK;
		item_ch.sensor_level = 1'b1;
		item_ch.column_index = '0;
		item_ch.column_data = '0;
		result_ch.ready = 1'b0;
		sb = new();
		sent = 0;
		results_taken = 0;
		cycles = 0;
		steady = 1'b0;
		held_once = 1'b0;
		drained_once = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: store extremes, ignored indexes, zero period, capture and re-arm
		write_column(8'd0, 16'hFFFF);
		write_column(8'd1, 16'hA5A5);
		write_column(8'd2, 16'h5A5A);
		write_column(8'd179, 16'h8001);
		write_column(8'd180, 16'h1234);
		write_column(8'd255, 16'hFFFF);
		tick(1'b1);
		tick(1'b1);
		tick(1'b1);
		tick(1'b0);
		tick(1'b0);
		tick(1'b1);
		tick(1'b0);
		write_column(8'd90, 16'h0F0F);
		repeat (6) tick(1'b1);
		write_column(8'd3, 16'h0000);
		tick(1'b0);
		tick(1'b1);

		// random: mostly full revolutions, some noise
		while (sent < TOTAL_REQUESTS) begin
			if ($urandom_range(0, 99) < 80)
				spin_revolution();
			else
				noise_burst();
			// hold off until everything has drained, once
			if (!drained_once && sent >= 700) begin
				drained_once = 1'b1;
				drain();
			end
		end
		item_ch.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d ticks and %0d column writes (%0d outside the store),",
			sb.tick_reqs, sb.write_reqs, sb.dropped_writes);
		$display("%0d captured revolutions, highest sector %0d, %0d mismatches.",
			sb.revolutions, sb.top_sector, sb.errors);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule : rotation_synced_column_sequencer_tb

// ===== sim.f =====
design/rscs_pkg.sv
design/rscs_if.sv
design/rscs_store.sv
design/rscs_sweep.sv
design/rotation_synced_column_sequencer.sv
tb/sv/rotation_synced_column_sequencer_tb.sv
